[src/srt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int ID_W         = 31;
   localparam int NAME_W       = 64;
   localparam int LETTER_W     = 8;
   localparam int DEF_CAPACITY = 16;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_BY_ID  = 2'd1,
      FUNC_BY_LTR = 2'd2,
      FUNC_REMOVE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STS_DONE    = 2'd0,
      STS_FULL    = 2'd1,
      STS_MISSING = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [NAME_W-1:0] name0;
      logic [NAME_W-1:0] name1;
      logic [NAME_W-1:0] name2;
      logic [NAME_W-1:0] name3;
   } rec_type;

   typedef struct packed {
      cell_op_type op;
      func_type    func;
      rec_type     word;
   } ctrl_type;

endpackage

[src/sorted_record_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_table
// Ordered table of up to CAPACITY records kept in a row of cells.
// A command is taken in idle, runs one update step, then one full rotation
// of the cell row that streams the table out of the head cell; the result
// words are registered. A new command is not taken until the rotation ends.
// Results come one per cycle and cannot be stalled by the receiver.
// Reset: empties the table at once; record storage itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_record_table #(
   parameter int CAPACITY = srt_pkg::DEF_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_func,
   input  logic [srt_pkg::ID_W-1:0]   req_id,
   input  logic [srt_pkg::NAME_W-1:0] req_name_word0,
   input  logic [srt_pkg::NAME_W-1:0] req_name_word1,
   input  logic [srt_pkg::NAME_W-1:0] req_name_word2,
   input  logic [srt_pkg::NAME_W-1:0] req_name_word3,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [CNT_W-1:0]           rsp_count,
   output logic                       rsp_entry_valid,
   output logic [srt_pkg::ID_W-1:0]   rsp_entry_id,
   output logic [srt_pkg::NAME_W-1:0] rsp_entry_name0,
   output logic [srt_pkg::NAME_W-1:0] rsp_entry_name1,
   output logic [srt_pkg::NAME_W-1:0] rsp_entry_name2,
   output logic [srt_pkg::NAME_W-1:0] rsp_entry_name3,
   output logic                       rsp_last
);
   import srt_pkg::*;

   ctrl_type         ctrl;
   logic [CNT_W-1:0] count;
   rec_type          rec [CAPACITY];
   logic             hit [CAPACITY+1];
   rec_type          rsp_entry;

   assign hit[0] = 1'b0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      srt_cell #(
         .CAPACITY (CAPACITY),
         .IDX      (g),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .count    (count),
         .prev_rec ((g == 0) ? rec_type'('0) : rec[(g == 0) ? 0 : g - 1]),
         .next_rec (rec[(g + 1) % CAPACITY]),
         .hit_prev (hit[g]),
         .hit_out  (hit[g+1]),
         .rec_out  (rec[g])
      );
   end

   srt_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_id          (req_id),
      .req_name_word0  (req_name_word0),
      .req_name_word1  (req_name_word1),
      .req_name_word2  (req_name_word2),
      .req_name_word3  (req_name_word3),
      .ctrl            (ctrl),
      .count           (count),
      .hit_any         (hit[CAPACITY]),
      .head_rec        (rec[0]),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_entry       (rsp_entry),
      .rsp_last        (rsp_last)
   );

   assign rsp_entry_id    = rsp_entry.id;
   assign rsp_entry_name0 = rsp_entry.name0;
   assign rsp_entry_name1 = rsp_entry.name1;
   assign rsp_entry_name2 = rsp_entry.name2;
   assign rsp_entry_name3 = rsp_entry.name3;

endmodule

[src/srt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_cell
// One table slot: holds a record, matches it against the request word and
// takes its own record, its left or its right neighbor's record, or the request word.
// ----------------------------------------------------------------------------
module srt_cell #(
   parameter int CAPACITY = srt_pkg::DEF_CAPACITY,
   parameter int IDX      = 0,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  srt_pkg::ctrl_type ctrl,
   input  logic [CNT_W-1:0]  count,
   input  srt_pkg::rec_type  prev_rec,
   input  srt_pkg::rec_type  next_rec,
   input  logic              hit_prev,
   output logic              hit_out,
   output srt_pkg::rec_type  rec_out
);
   import srt_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;
   logic    occupied;
   logic    hit;

   assign occupied = CNT_W'(IDX) < count;

   always_comb begin
      case (ctrl.func)
         FUNC_APPEND: hit = !occupied;
         FUNC_BY_ID:  hit = !occupied || (rec_ff.id >= ctrl.word.id);
         FUNC_BY_LTR: hit = !occupied ||
                            (rec_ff.name0[LETTER_W-1:0] > ctrl.word.name0[LETTER_W-1:0]);
         FUNC_REMOVE: hit = occupied && (rec_ff.id == ctrl.word.id);
         default:     hit = 1'b0;
      endcase
   end

   assign hit_out = hit_prev || hit;

   always_comb begin
      rec_in = rec_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (hit_prev) rec_in = prev_rec;
            else if (hit) rec_in = ctrl.word;
         end
         OP_REMOVE: begin
            if (hit_prev || hit) rec_in = next_rec;
         end
         OP_ROTATE: rec_in = next_rec;
         default:   rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_out = rec_ff;

endmodule

[src/srt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer: takes a command word, runs the update step on the cell row,
// then rotates the row once around and sends the table out from the head.
// ----------------------------------------------------------------------------
module srt_ctrl #(
   parameter int CAPACITY = srt_pkg::DEF_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_func,
   input  logic [srt_pkg::ID_W-1:0] req_id,
   input  logic [srt_pkg::NAME_W-1:0] req_name_word0,
   input  logic [srt_pkg::NAME_W-1:0] req_name_word1,
   input  logic [srt_pkg::NAME_W-1:0] req_name_word2,
   input  logic [srt_pkg::NAME_W-1:0] req_name_word3,
   output srt_pkg::ctrl_type        ctrl,
   output logic [CNT_W-1:0]         count,
   input  logic                     hit_any,
   input  srt_pkg::rec_type         head_rec,
   output logic                     rsp_strobe,
   output logic [1:0]               rsp_status,
   output logic [CNT_W-1:0]         rsp_count,
   output logic                     rsp_entry_valid,
   output srt_pkg::rec_type         rsp_entry,
   output logic                     rsp_last
);
   import srt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_OPER = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] step_ff, step_in;
   status_type       status_ff, status_in;
   func_type         func_ff;
   rec_type          req_ff;
   logic             accept;
   logic             full;
   logic             emit;
   logic             step_done;

   logic             strobe_ff, strobe_in;
   logic             last_ff, last_in;
   logic             evalid_ff, evalid_in;
   rec_type          entry_ff, entry_in;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = state_ff != ST_IDLE;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign step_done = step_ff == CNT_W'(CAPACITY - 1);
   assign emit      = (step_ff < count_ff) ||
                      ((count_ff == '0) && (step_ff == '0));

   always_comb begin
      ctrl.func = func_ff;
      ctrl.word = req_ff;
      case (state_ff)
         ST_OPER: begin
            if (func_ff == FUNC_REMOVE) ctrl.op = OP_REMOVE;
            else if (full) ctrl.op = OP_HOLD;
            else ctrl.op = OP_INSERT;
         end
         ST_EMIT: ctrl.op = OP_ROTATE;
         default: ctrl.op = OP_HOLD;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_OPER;
         end
         ST_OPER: begin
            step_in  = '0;
            state_in = ST_EMIT;
            if (func_ff == FUNC_REMOVE) begin
               if (hit_any) begin
                  status_in = STS_DONE;
                  count_in  = count_ff - 1'b1;
               end else begin
                  status_in = STS_MISSING;
               end
            end else if (full) begin
               status_in = STS_FULL;
            end else begin
               status_in = STS_DONE;
               count_in  = count_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            step_in = step_ff + 1'b1;
            if (step_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      strobe_in = (state_ff == ST_EMIT) && emit;
      evalid_in = count_ff != '0;
      last_in   = (count_ff == '0) || (step_ff == count_ff - 1'b1);
      entry_in  = evalid_in ? head_rec : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         step_ff   <= '0;
         status_ff <= STS_DONE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         step_ff   <= step_in;
         status_ff <= status_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff      <= func_type'(req_func);
         req_ff.id    <= req_id;
         req_ff.name0 <= req_name_word0;
         req_ff.name1 <= req_name_word1;
         req_ff.name2 <= req_name_word2;
         req_ff.name3 <= req_name_word3;
      end
      last_ff   <= last_in;
      evalid_ff <= evalid_in;
      entry_ff  <= entry_in;
   end

   assign count           = count_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_count       = count_ff;
   assign rsp_entry_valid = evalid_ff;
   assign rsp_entry       = entry_ff;
   assign rsp_last        = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("record count above capacity");

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      strobe_in |-> state_ff == ST_EMIT)
      else $error("result word outside emit phase");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |=> !strobe_ff)
      else $error("result word after last");

   a_accept_to_oper: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_OPER)
      else $error("accepted command not executed");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OPER && ctrl.op == OP_HOLD) |=> $stable(count_ff))
      else $error("refused insert changed count");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_record_table. A queue of commands (a short
// directed list, then random fill and drain phases) feeds a bursty driver. A
// table model updated on every accepted command predicts the dump words, and
// a monitor checks each result word field by field against them.
// ----------------------------------------------------------------------------
module testbench;
   import srt_pkg::*;

   localparam int CAPACITY    = DEF_CAPACITY;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int RAND_ITEMS  = 137;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      func_type          func;
      logic [ID_W-1:0]   id;
      logic [NAME_W-1:0] name0, name1, name2, name3;
      bit                drain_first;
   } table_cmd_type;

   typedef struct {
      status_type       status;
      logic [CNT_W-1:0] count;
      logic             valid;
      rec_type          rec;
      logic             last;
   } table_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_func;
   logic [ID_W-1:0]     req_id;
   logic [NAME_W-1:0]   req_name_word0, req_name_word1, req_name_word2, req_name_word3;
   logic                rsp_strobe;
   logic [1:0]          rsp_status;
   logic [CNT_W-1:0]    rsp_count;
   logic                rsp_entry_valid;
   logic [ID_W-1:0]     rsp_entry_id;
   logic [NAME_W-1:0]   rsp_entry_name0, rsp_entry_name1, rsp_entry_name2, rsp_entry_name3;
   logic                rsp_last;

   table_cmd_type   cmd_queue[$];
   table_row_type   pending_rows[$];
   rec_type         table_q[$];
   logic [ID_W-1:0] gen_ids[$];

   logic took_word = 1'b0;
   logic live      = 1'b0;
   int   burst_left = 1;
   int   gap_left   = 0;
   int   cycle_count = 0;
   int   mismatches = 0;
   int   items_taken = 0;
   int   rows_checked = 0;
   int   refused = 0;
   int   misses = 0;
   int   empty_dumps = 0;
   int   peak_count = 0;

   sorted_record_table dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_id          (req_id),
      .req_name_word0  (req_name_word0),
      .req_name_word1  (req_name_word1),
      .req_name_word2  (req_name_word2),
      .req_name_word3  (req_name_word3),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_entry_id    (rsp_entry_id),
      .rsp_entry_name0 (rsp_entry_name0),
      .rsp_entry_name1 (rsp_entry_name1),
      .rsp_entry_name2 (rsp_entry_name2),
      .rsp_entry_name3 (rsp_entry_name3),
      .rsp_last        (rsp_last)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [NAME_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [NAME_W-1:0] named(logic [7:0] letter);
      logic [NAME_W-1:0] w;
      w = rand_word();
      w[7:0] = letter;
      return w;
   endfunction

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(0, 1) == 0)
         return 8'h41 + 8'($urandom_range(0, 3));
      return 8'($urandom);
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4, 5: return ID_W'($urandom_range(0, 15));
         default: return ID_W'($urandom);
      endcase
   endfunction

   // Queue a command and track which ids the table will hold.
   task automatic queue_cmd(func_type f, logic [ID_W-1:0] id, logic [NAME_W-1:0] n0,
                            logic [NAME_W-1:0] n1, logic [NAME_W-1:0] n2,
                            logic [NAME_W-1:0] n3, bit drain);
      table_cmd_type c;
      int hit;
      c = '{f, id, n0, n1, n2, n3, drain};
      cmd_queue.push_back(c);
      hit = -1;
      if (f == FUNC_REMOVE) begin
         foreach (gen_ids[k])
            if (hit < 0 && gen_ids[k] == id)
               hit = k;
         if (hit >= 0)
            gen_ids.delete(hit);
      end else if (gen_ids.size() < CAPACITY) begin
         gen_ids.push_back(id);
      end
   endtask

   // Apply one command to the table and queue the dump words it produces.
   function automatic void update_table(func_type f, logic [ID_W-1:0] id,
                                        logic [NAME_W-1:0] n0, logic [NAME_W-1:0] n1,
                                        logic [NAME_W-1:0] n2, logic [NAME_W-1:0] n3);
      status_type    sts;
      rec_type       r;
      table_row_type row;
      int            pos;
      sts = STS_DONE;
      r = '{id, n0, n1, n2, n3};
      pos = 0;
      if (f == FUNC_REMOVE) begin
         while (pos < table_q.size() && table_q[pos].id != id)
            pos++;
         if (pos == table_q.size())
            sts = STS_MISSING;
         else
            table_q.delete(pos);
      end else if (table_q.size() >= CAPACITY) begin
         sts = STS_FULL;
      end else begin
         case (f)
            FUNC_APPEND: pos = table_q.size();
            FUNC_BY_ID: begin
               while (pos < table_q.size() && table_q[pos].id < id)
                  pos++;
            end
            default: begin
               while (pos < table_q.size() && table_q[pos].name0[7:0] <= n0[7:0])
                  pos++;
            end
         endcase
         table_q.insert(pos, r);
      end
      if (sts == STS_FULL)
         refused++;
      if (sts == STS_MISSING)
         misses++;
      if (table_q.size() > peak_count)
         peak_count = table_q.size();
      if (table_q.size() == 0) begin
         empty_dumps++;
         row = '{sts, '0, 1'b0, '0, 1'b1};
         pending_rows.push_back(row);
      end else begin
         foreach (table_q[k]) begin
            row = '{sts, CNT_W'(table_q.size()), 1'b1, table_q[k], k == table_q.size() - 1};
            pending_rows.push_back(row);
         end
      end
   endfunction

   function automatic void check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // Driver: bursts of commands with random gaps, optional drain before a command.
   always @(negedge clock) begin : driver
      table_cmd_type c;
      logic          next_start;
      next_start = start && !took_word;
      if (live && !next_start) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
         end else if (cmd_queue.size() != 0 &&
                      !(cmd_queue[0].drain_first && pending_rows.size() != 0)) begin
            c = cmd_queue.pop_front();
            req_func       <= c.func;
            req_id         <= c.id;
            req_name_word0 <= c.name0;
            req_name_word1 <= c.name1;
            req_name_word2 <= c.name2;
            req_name_word3 <= c.name3;
            next_start = 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(10, 30);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 6);
                  gap_left   = $urandom_range(1, 24);
               end
            end
         end
      end
      start <= next_start;
   end

   // Monitor: checks result words, updates the table on each accepted word.
   always @(posedge clock) begin : monitor
      table_row_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      live <= !reset;
      if (reset) begin
         took_word <= 1'b0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (pending_rows.size() == 0) begin
               $error("result word with no expectation pending");
               mismatches++;
            end else begin
               want = pending_rows.pop_front();
               rows_checked++;
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("count", 64'(want.count), 64'(rsp_count));
               check_field("entry_valid", 64'(want.valid), 64'(rsp_entry_valid));
               check_field("entry_id", 64'(want.rec.id), 64'(rsp_entry_id));
               check_field("entry_name0", want.rec.name0, rsp_entry_name0);
               check_field("entry_name1", want.rec.name1, rsp_entry_name1);
               check_field("entry_name2", want.rec.name2, rsp_entry_name2);
               check_field("entry_name3", want.rec.name3, rsp_entry_name3);
               check_field("last", 64'(want.last), 64'(rsp_last));
            end
         end else if (rsp_strobe !== 1'b0) begin
            $error("rsp_strobe unknown");
            mismatches++;
         end
         if (start && !busy) begin
            items_taken++;
            update_table(func_type'(req_func), req_id, req_name_word0, req_name_word1,
                         req_name_word2, req_name_word3);
         end
         took_word <= start && !busy;
      end
   end

   initial begin : stimulus
      bit              fill_phase;
      int              roll;
      func_type        f;
      logic [ID_W-1:0] id;
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = '0;
      req_id         = '0;
      req_name_word0 = '0;
      req_name_word1 = '0;
      req_name_word2 = '0;
      req_name_word3 = '0;
      fill_phase     = 1'b0;

      // Directed: empty table, key extremes, equal keys, full table, removals.
      queue_cmd(FUNC_REMOVE, 31'd5, '0, '0, '0, '0, 1'b0);
      queue_cmd(FUNC_APPEND, '0, '0, '0, '0, '0, 1'b0);
      queue_cmd(FUNC_APPEND, '1, '1, '1, '1, '1, 1'b0);
      queue_cmd(FUNC_BY_ID, '0, named(8'h10), rand_word(), rand_word(), rand_word(), 1'b0);
      queue_cmd(FUNC_BY_ID, '1, named(8'h20), rand_word(), rand_word(), rand_word(), 1'b0);
      queue_cmd(FUNC_BY_LTR, 31'd20, named(8'h00), rand_word(), rand_word(), rand_word(),
                1'b0);
      queue_cmd(FUNC_BY_LTR, 31'd21, named(8'hFF), rand_word(), rand_word(), rand_word(),
                1'b0);
      for (int k = 0; k < 2; k++)
         queue_cmd(FUNC_BY_LTR, ID_W'(22 + k), named(8'h41), rand_word(), rand_word(),
                   rand_word(), 1'b0);
      for (int k = 0; k < 8; k++)
         queue_cmd(func_type'(k % 3), pick_id(), named(8'(8'h40 + k)), rand_word(),
                   rand_word(), rand_word(), 1'b0);
      for (int k = 0; k < 3; k++)
         queue_cmd(func_type'(k), pick_id(), named(pick_letter()), rand_word(), rand_word(),
                   rand_word(), 1'b0);
      queue_cmd(FUNC_REMOVE, '0, '0, '0, '0, '0, 1'b0);
      queue_cmd(FUNC_REMOVE, 31'h5A5A_5A5A, '1, '1, '1, '1, 1'b0);
      queue_cmd(FUNC_REMOVE, '1, '0, '0, '0, '0, 1'b0);

      // Random: alternate fill-heavy and drain-heavy phases.
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 24 == 0)
            fill_phase = !fill_phase;
         roll = $urandom_range(0, 99);
         if (roll < (fill_phase ? 25 : 75)) begin
            f = FUNC_REMOVE;
            if (gen_ids.size() != 0 && $urandom_range(0, 5) != 0)
               id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
            else
               id = pick_id();
         end else begin
            f  = func_type'($urandom_range(0, 2));
            id = pick_id();
         end
         queue_cmd(f, id, named(pick_letter()), rand_word(), rand_word(), rand_word(),
                   n == 0 || n % 45 == 44);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      #1;
      while (cmd_queue.size() != 0 || start || pending_rows.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (CAPACITY + 8) @(posedge clock);

      if (pending_rows.size() != 0) begin
         $error("%0d expected result words never arrived", pending_rows.size());
         mismatches++;
      end
      $display("covered %0d commands and %0d dump words; peak occupancy %0d of %0d",
               items_taken, rows_checked, peak_count, CAPACITY);
      $display("refused inserts %0d, removes of absent ids %0d, empty-table dumps %0d",
               refused, misses, empty_dumps);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
